// ===== rtl/sleep_timer_delta_queue_assert.svh =====
// Assertion macros for the sleep timer delta queue.
`ifndef SLEEP_TIMER_DELTA_QUEUE_ASSERT_SVH
`define SLEEP_TIMER_DELTA_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
`define STDQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define STDQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define STDQ_ASSERT(label, prop, msg)
`define STDQ_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/stdq_pkg.sv =====
`timescale 1ns / 1ps

package stdq_pkg;

  localparam int unsigned TPM_W    = 20;
  localparam int unsigned DELAY_W  = 20;
  localparam int unsigned TID_W    = 16;
  localparam int unsigned DELTA_W  = 40;
  localparam int unsigned SUMD_W   = DELTA_W + 1;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned MAX_WAKE = 16;
  localparam int unsigned WAKE_W   = $clog2(MAX_WAKE + 1);
  localparam int unsigned PADDR_W  = 3;
  localparam int unsigned PDATA_W  = 32;

  typedef enum logic [0:0] {
    REG_TICK_SCALE = 1'b0
  } reg_idx_e;

  typedef enum logic [0:0] {
    ACT_ADD  = 1'b0,
    ACT_TICK = 1'b1
  } act_e;

  typedef enum logic [1:0] {
    ST_ACCEPT = 2'd0,
    ST_FULL   = 2'd1,
    ST_WOKEN  = 2'd2,
    ST_NONE   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_REJ,
    S_WRD,
    S_WSUM,
    S_WDEC,
    S_SRD,
    S_SWR,
    S_INS,
    S_TRD,
    S_TCHK,
    S_TNONE,
    S_TLAST
  } state_e;

  typedef struct packed {
    logic [TID_W-1:0]   thread;
    logic [DELTA_W-1:0] delta;
  } slot_t;

  typedef struct packed {
    logic    load;
    logic    mul;
    logic    walk_rd;
    logic    walk_sum;
    logic    walk_adv;
    logic    walk_stop;
    logic    shift_rd;
    logic    shift_wr;
    logic    insert;
    logic    tick_rd;
    logic    tick_wb;
    logic    tick_pop;
    logic    emit;
    logic    emit_pend;
    logic    emit_last;
    status_e emit_status;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic full;
    logic empty;
    logic idx_end;
    logic sj_at_idx;
    logic le;
    logic first;
    logic zero;
    logic wake_done;
  } stat_t;

endpackage

// ===== rtl/stdq_ctrl.sv =====
`timescale 1ns / 1ps

module stdq_ctrl
  import stdq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic [0:0]  action_i,
  output logic        in_ready_o,
  input  stat_t       stat_i,
  output cmd_t        cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.emit_status = ST_ACCEPT;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = (act_e'(action_i) == ACT_TICK) ? S_TRD : S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = stat_i.full ? S_REJ : S_WRD;
      end
      S_REJ: begin
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = ST_FULL;
          state_d = S_IDLE;
        end
      end
      S_WRD: begin
        if (stat_i.idx_end) begin
          state_d = S_SRD;
        end else begin
          cmd_o.walk_rd = 1'b1;
          state_d = S_WSUM;
        end
      end
      S_WSUM: begin
        cmd_o.walk_sum = 1'b1;
        state_d = S_WDEC;
      end
      S_WDEC: begin
        if (stat_i.le) begin
          cmd_o.walk_adv = 1'b1;
          state_d = S_WRD;
        end else begin
          cmd_o.walk_stop = 1'b1;
          state_d = S_SRD;
        end
      end
      S_SRD: begin
        if (stat_i.sj_at_idx) begin
          state_d = S_INS;
        end else begin
          cmd_o.shift_rd = 1'b1;
          state_d = S_SWR;
        end
      end
      S_SWR: begin
        cmd_o.shift_wr = 1'b1;
        state_d = S_SRD;
      end
      S_INS: begin
        if (stat_i.out_free) begin
          cmd_o.insert      = 1'b1;
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = ST_ACCEPT;
          state_d = S_IDLE;
        end
      end
      S_TRD: begin
        if (stat_i.empty) begin
          state_d = S_TNONE;
        end else begin
          cmd_o.tick_rd = 1'b1;
          state_d = S_TCHK;
        end
      end
      S_TNONE: begin
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = ST_NONE;
          state_d = S_IDLE;
        end
      end
      S_TCHK: begin
        if (!stat_i.zero) begin
          if (stat_i.out_free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.emit_last = 1'b1;
            if (stat_i.first) begin
              cmd_o.tick_wb     = 1'b1;
              cmd_o.emit_status = ST_NONE;
            end else begin
              cmd_o.emit_pend   = 1'b1;
              cmd_o.emit_status = ST_WOKEN;
            end
            state_d = S_IDLE;
          end
        end else if (stat_i.first || stat_i.out_free) begin
          cmd_o.tick_pop = 1'b1;
          if (!stat_i.first) begin
            cmd_o.emit        = 1'b1;
            cmd_o.emit_pend   = 1'b1;
            cmd_o.emit_status = ST_WOKEN;
          end
          state_d = stat_i.wake_done ? S_TLAST : S_TRD;
        end
      end
      S_TLAST: begin
        if (stat_i.out_free) begin
          cmd_o.emit        = 1'b1;
          cmd_o.emit_pend   = 1'b1;
          cmd_o.emit_last   = 1'b1;
          cmd_o.emit_status = ST_WOKEN;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/stdq_dp.sv =====
`timescale 1ns / 1ps

module stdq_dp
  import stdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [TPM_W-1:0]   tpm_i,
  input  logic [DELAY_W-1:0] delay_ms_i,
  input  logic [TID_W-1:0]   thread_id_i,
  input  cmd_t               cmd_i,
  output stat_t              stat_o,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [1:0]         status_o,
  output logic [TID_W-1:0]   woken_thread_o,
  output logic               last_o,
  output logic [OCC_W-1:0]   occupancy_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + SUM_W'(off);
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return s[PTR_W-1:0];
  endfunction

  slot_t mem_q [DEPTH];
  slot_t rdata_q;

  logic [CNT_W-1:0]   count_q, count_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [WAKE_W-1:0]  wake_n_q;
  logic               out_valid_q;

  logic [DELAY_W-1:0] delay_q;
  logic [TID_W-1:0]   tid_q;
  logic [DELTA_W-1:0] ticks_q, cum_q, succ_q;
  logic [SUMD_W-1:0]  sum_q;
  logic [CNT_W-1:0]   idx_q, sj_q;
  logic [TID_W-1:0]   pend_q;
  logic [OCC_W-1:0]   pend_occ_q;
  logic [1:0]         out_status_q;
  logic [TID_W-1:0]   out_thread_q;
  logic               out_last_q;
  logic [OCC_W-1:0]   out_occ_q;

  logic [DELTA_W-1:0] rel;
  logic [CNT_W-1:0]   sj_m1;
  logic               rd_en, wr_en;
  logic [PTR_W-1:0]   raddr, waddr;
  slot_t              wdata;

  assign rel   = ticks_q - cum_q;
  assign sj_m1 = sj_q - 1'b1;

  always_comb begin
    rd_en = cmd_i.walk_rd | cmd_i.shift_rd | cmd_i.tick_rd;
    raddr = head_q;
    if (cmd_i.walk_rd) begin
      raddr = wrap(head_q, idx_q);
    end else if (cmd_i.shift_rd) begin
      raddr = wrap(head_q, sj_m1);
    end
    wr_en = cmd_i.shift_wr | cmd_i.insert | cmd_i.tick_wb;
    waddr = head_q;
    wdata.thread = rdata_q.thread;
    wdata.delta  = rdata_q.delta - 1'b1;
    if (cmd_i.shift_wr) begin
      waddr = wrap(head_q, sj_q);
      wdata.delta = (sj_m1 == idx_q) ? succ_q : rdata_q.delta;
    end else if (cmd_i.insert) begin
      waddr = wrap(head_q, idx_q);
      wdata.thread = tid_q;
      wdata.delta  = rel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[waddr] <= wdata;
    if (rd_en) rdata_q <= mem_q[raddr];
  end

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    if (cmd_i.insert) count_d = count_q + 1'b1;
    if (cmd_i.tick_pop) begin
      count_d = count_q - 1'b1;
      head_d  = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      head_q      <= '0;
      wake_n_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
      if (cmd_i.load) begin
        wake_n_q <= '0;
      end else if (cmd_i.tick_pop) begin
        wake_n_q <= wake_n_q + 1'b1;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      delay_q <= delay_ms_i;
      tid_q   <= thread_id_i;
    end
    if (cmd_i.mul) begin
      ticks_q <= DELTA_W'(delay_q) * DELTA_W'(tpm_i);
      cum_q   <= '0;
      idx_q   <= '0;
      sj_q    <= count_q;
    end
    if (cmd_i.walk_sum) sum_q <= SUMD_W'(cum_q) + SUMD_W'(rdata_q.delta);
    if (cmd_i.walk_adv) begin
      cum_q <= sum_q[DELTA_W-1:0];
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.walk_stop) succ_q <= DELTA_W'(sum_q - SUMD_W'(ticks_q));
    if (cmd_i.shift_wr) sj_q <= sj_m1;
    if (cmd_i.tick_pop) begin
      pend_q     <= rdata_q.thread;
      pend_occ_q <= OCC_W'(count_d);
    end
    if (cmd_i.emit) begin
      out_status_q <= cmd_i.emit_status;
      out_last_q   <= cmd_i.emit_last;
      if (cmd_i.emit_pend) begin
        out_thread_q <= pend_q;
        out_occ_q    <= pend_occ_q;
      end else begin
        out_thread_q <= '0;
        out_occ_q    <= OCC_W'(count_d);
      end
    end
  end

  always_comb begin
    stat_o.out_free  = !out_valid_q || out_ready_i;
    stat_o.full      = (count_q == CNT_W'(DEPTH));
    stat_o.empty     = (count_q == '0);
    stat_o.idx_end   = (idx_q == count_q);
    stat_o.sj_at_idx = (sj_q == idx_q);
    stat_o.le        = (sum_q <= SUMD_W'(ticks_q));
    stat_o.first     = (wake_n_q == '0);
    stat_o.zero      = stat_o.first ? (rdata_q.delta <= DELTA_W'(1))
                                    : (rdata_q.delta == '0);
    stat_o.wake_done = (wake_n_q == WAKE_W'(MAX_WAKE - 1)) ||
                       (count_q == CNT_W'(1));
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign woken_thread_o = out_thread_q;
  assign last_o         = out_last_q;
  assign occupancy_o    = out_occ_q;

endmodule

// ===== rtl/sleep_timer_delta_queue.sv =====
// Channel  Handshake                    Payload
// in       in_valid_i / in_ready_o      action_i, delay_ms_i, thread_id_i
// out      out_valid_o / out_ready_i    status_o, woken_thread_o, last_o, occupancy_o
// cfg      psel, penable, pwrite        paddr, pwdata, prdata (pready tied high)
//
// Add: the delay is scaled to ticks, then a walk reads and sums queued entries up to the
// new deadline, the later entries are shifted up one slot and the new entry is written;
// one slot read per walk step and per shifted entry. A full queue is rejected without
// a walk. Tick: the head entry is read and counted down; entries that reach zero are
// popped and reported as woken until none is due, the queue empties or the wake limit
// is hit; one memory read per head entry.
// Reset clears the count and head pointer at once; no clearing pass.
// A stalled output holds the controller only where a new result must be sent.
`timescale 1ns / 1ps

module sleep_timer_delta_queue
  import stdq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [0:0]         action_i,
  input  logic [DELAY_W-1:0] delay_ms_i,
  input  logic [TID_W-1:0]   thread_id_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [TID_W-1:0]   woken_thread_o,
  output logic               last_o,
  output logic [OCC_W-1:0]   occupancy_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  `include "sleep_timer_delta_queue_assert.svh"

  logic [TPM_W-1:0] tpm_q;
  logic             reg_hit;
  cmd_t             cmd;
  stat_t            stat;

  assign pready  = 1'b1;
  assign reg_hit = (reg_idx_e'(paddr[2]) == REG_TICK_SCALE);
  assign prdata  = reg_hit ? PDATA_W'(tpm_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q <= TPM_W'(1);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      tpm_q <= pwdata[TPM_W-1:0];
    end
  end

  stdq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  stdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tpm_i          (tpm_q),
    .delay_ms_i     (delay_ms_i),
    .thread_id_i    (thread_id_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .woken_thread_o (woken_thread_o),
    .last_o         (last_o),
    .occupancy_o    (occupancy_o)
  );

  `STDQ_ASSERT(a_one_at_a_time, in_valid_i && in_ready_o |=> !in_ready_o, "input taken while busy")
  `STDQ_ASSERT(a_single_last, out_valid_o && status_o != ST_WOKEN |-> last_o, "single result not last")
  `STDQ_ASSERT(a_no_thread, out_valid_o && status_o != ST_WOKEN |-> woken_thread_o == '0, "stray thread id")
  `STDQ_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import stdq_pkg::*;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned TPM_MAX    = (1 << TPM_W) - 1;
  localparam int unsigned DELAY_MAX  = (1 << DELAY_W) - 1;

  typedef struct packed {
    status_e          status;
    logic [TID_W-1:0] thread;
    logic             last;
    logic [OCC_W-1:0] occ;
  } report_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [0:0]         action_i;
  logic [DELAY_W-1:0] delay_ms_i;
  logic [TID_W-1:0]   thread_id_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic [TID_W-1:0]   woken_thread_o;
  logic               last_o;
  logic [OCC_W-1:0]   occupancy_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  sleep_timer_delta_queue #(.DEPTH(DEPTH)) u_top (.*);

  always #10 clk_i = ~clk_i;

  report_t            expected_reports[$];
  logic [TID_W-1:0]   sleeper_tid[DEPTH];
  logic [DELTA_W-1:0] sleeper_delta[DEPTH];
  int unsigned        sleepers   = 0;
  logic [TPM_W-1:0]   tick_scale = TPM_W'(1);
  int unsigned        mismatches = 0;
  int unsigned        idle_cycles = 0;
  int                 burst_left = 0;
  bit                 sender_busy = 1'b0;
  rx_mode_e           rx_mode = RX_OPEN;
  int                 rx_span = 0;

  function automatic void note_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void push_report(status_e st, logic [TID_W-1:0] tid, logic last);
    report_t r;
    r.status = st;
    r.thread = tid;
    r.last   = last;
    r.occ    = OCC_W'(sleepers);
    expected_reports.push_back(r);
  endfunction

  function automatic void advance_delta_queue(act_e act, logic [DELAY_W-1:0] delay,
                                              logic [TID_W-1:0] tid);
    logic [63:0]        deadline;
    logic [63:0]        elapsed;
    logic [DELTA_W-1:0] rel;
    logic [TID_W-1:0]   wake_tid;
    int unsigned        pos;
    int unsigned        woken;
    int unsigned        j;
    report_t            tail;
    if (act == ACT_ADD) begin
      if (sleepers >= DEPTH) begin
        push_report(ST_FULL, '0, 1'b1);
        return;
      end
      deadline = 64'(delay) * 64'(tick_scale);
      elapsed  = 0;
      pos      = 0;
      while (pos < sleepers && elapsed + 64'(sleeper_delta[pos]) <= deadline) begin
        elapsed += 64'(sleeper_delta[pos]);
        pos++;
      end
      rel = DELTA_W'(deadline - elapsed);
      for (j = sleepers; j > pos; j--) begin
        sleeper_tid[j]   = sleeper_tid[j-1];
        sleeper_delta[j] = sleeper_delta[j-1];
      end
      sleeper_tid[pos]   = tid;
      sleeper_delta[pos] = rel;
      sleepers++;
      if (pos + 1 < sleepers) sleeper_delta[pos+1] = sleeper_delta[pos+1] - rel;
      push_report(ST_ACCEPT, '0, 1'b1);
    end else begin
      if (sleepers == 0) begin
        push_report(ST_NONE, '0, 1'b1);
        return;
      end
      if (sleeper_delta[0] != 0) sleeper_delta[0] = sleeper_delta[0] - 1'b1;
      woken = 0;
      while (woken < MAX_WAKE && sleepers > 0 && sleeper_delta[0] == 0) begin
        wake_tid = sleeper_tid[0];
        for (j = 1; j < sleepers; j++) begin
          sleeper_tid[j-1]   = sleeper_tid[j];
          sleeper_delta[j-1] = sleeper_delta[j];
        end
        sleepers--;
        push_report(ST_WOKEN, wake_tid, 1'b0);
        woken++;
      end
      if (woken == 0) begin
        push_report(ST_NONE, '0, 1'b1);
      end else begin
        tail = expected_reports.pop_back();
        tail.last = 1'b1;
        expected_reports.push_back(tail);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    report_t got;
    report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.status = status_e'(status_o);
      got.thread = woken_thread_o;
      got.last   = last_o;
      got.occ    = occupancy_o;
      if (expected_reports.size() == 0) begin
        note_mismatch($sformatf("unexpected result status %0d thread %h last %0b occupancy %0d",
                                got.status, got.thread, got.last, got.occ));
      end else begin
        want = expected_reports.pop_front();
        if (got !== want)
          note_mismatch($sformatf({"expected status %0d thread %h last %0b occupancy %0d, ",
                                   "got status %0d thread %h last %0b occupancy %0d"},
                                  want.status, want.thread, want.last, want.occ,
                                  got.status, got.thread, got.last, got.occ));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 3));
      rx_span <= $urandom_range(20, 120);
    end else begin
      rx_span <= rx_span - 1;
    end
    case (rx_mode)
      RX_OPEN:   out_ready_i <= 1'b1;
      RX_COIN:   out_ready_i <= ($urandom_range(0, 1) == 1);
      RX_SPARSE: out_ready_i <= (rx_span % 8 == 0);
      default:   out_ready_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_event(act_e act, logic [DELAY_W-1:0] delay, logic [TID_W-1:0] tid);
    if (!sender_busy) begin
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    delay_ms_i  <= delay;
    thread_id_i <= tid;
    sender_busy = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    advance_delta_queue(act, delay, tid);
    burst_left--;
    @(negedge clk_i);
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      sender_busy = 1'b0;
    end
  endtask

  task automatic wait_all_reported();
    if (sender_busy) begin
      in_valid_i <= 1'b0;
      sender_busy = 1'b0;
    end
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_tick_scale(logic [TPM_W-1:0] value);
    wait_all_reported();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(REG_TICK_SCALE));
    pwdata  <= PDATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tick_scale = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[TPM_W-1:0] !== value)
      note_mismatch($sformatf("tick scale read %h, written %h", prdata, value));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_random_events(int n, int unsigned delay_cap, int unsigned tick_weight);
    act_e               act;
    logic [DELAY_W-1:0] delay;
    for (int k = 0; k < n; k++) begin
      act = ($urandom_range(0, DEPTH + 3) < sleepers + tick_weight) ? ACT_TICK : ACT_ADD;
      delay = ($urandom_range(0, 3) == 0) ? '0 : DELAY_W'($urandom_range(0, delay_cap));
      send_event(act, delay, TID_W'($urandom));
    end
  endtask

  task automatic test_insert_order();
    send_event(ACT_TICK, DELAY_W'(DELAY_MAX), '1);
    send_event(ACT_ADD, '0, 16'h0000);
    send_event(ACT_ADD, DELAY_W'(3), 16'hFFFF);
    send_event(ACT_ADD, DELAY_W'(1), 16'h5555);
    send_event(ACT_ADD, DELAY_W'(1), 16'hAAAA);
    repeat (4) send_event(ACT_TICK, DELAY_W'($urandom), TID_W'($urandom));
    wait_all_reported();
  endtask

  task automatic test_full_queue_zero_scale();
    write_tick_scale('0);
    send_event(ACT_ADD, DELAY_W'(DELAY_MAX), TID_W'($urandom));
    send_event(ACT_ADD, '0, TID_W'($urandom));
    repeat (DEPTH - 2) send_event(ACT_ADD, DELAY_W'($urandom), TID_W'($urandom));
    send_event(ACT_ADD, DELAY_W'(DELAY_MAX), 16'hFFFF);
    send_event(ACT_TICK, '0, '0);
    wait_all_reported();
  endtask

  task automatic test_random_unit_scale();
    write_tick_scale(TPM_W'(1));
    send_random_events(70, 12, 2);
    wait_all_reported();
  endtask

  task automatic test_random_small_scale();
    write_tick_scale(TPM_W'(2));
    send_random_events(30, 8, 2);
    write_tick_scale(TPM_W'(3));
    send_random_events(30, 8, 3);
    write_tick_scale(TPM_W'($urandom_range(1, 4)));
    send_random_events(22, 6, 2);
    wait_all_reported();
  endtask

  task automatic test_random_zero_scale();
    write_tick_scale('0);
    send_random_events(40, DELAY_MAX, 0);
    wait_all_reported();
  endtask

  task automatic test_random_wide_scale();
    write_tick_scale(TPM_W'(TPM_MAX));
    send_event(ACT_ADD, DELAY_W'(DELAY_MAX), 16'hFFFF);
    send_random_events(40, DELAY_MAX, 1);
    write_tick_scale(TPM_W'($urandom_range(1000, TPM_MAX - 1)));
    send_random_events(50, DELAY_MAX, 2);
    wait_all_reported();
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    action_i    = ACT_ADD;
    delay_ms_i  = '0;
    thread_id_i = '0;
    out_ready_i = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_insert_order();
    test_full_queue_zero_scale();
    test_random_unit_scale();
    test_random_small_scale();
    test_random_zero_scale();
    test_random_wide_scale();

    wait_all_reported();
    repeat (64) @(posedge clk_i);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
